### rtl/core/cau_pkg.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Shared widths, op codes, item kinds and the record passed from the front
// end to the back end through the queue.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

    // Data format: signed fixed point, DW bits with FW fraction bits.
    localparam int DW = 16;
    localparam int FW = 8;

    // Exact product width, divider remainder width, overflow compare width.
    localparam int PW = 2 * DW;
    localparam int RW = PW + DW;
    localparam int CW = PW + DW + FW;

    // Back end pipeline: one setup stage plus one stage per quotient bit.
    localparam int NST = DW + 1;

    // Queue between the front end and the back end.
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    // Stream widths.
    localparam int IN_TW  = ((4 * DW + 7) / 8) * 8;
    localparam int OUT_TW = ((2 * DW + 7) / 8) * 8;
    localparam int IN_UW  = 3;
    localparam int OUT_UW = 2;

    // Op codes.
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_MAG = 3'd4;
    localparam logic [2:0] OP_SUP = 3'd5;

    // Item kinds seen by the back end.
    localparam logic [1:0] K_DIRECT = 2'd0;
    localparam logic [1:0] K_DIV    = 2'd1;
    localparam logic [1:0] K_MAG    = 2'd2;

    // Limits of the signed data range.
    localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

    // Classified request from the front end.
    typedef struct packed {
        logic [1:0]           kind;
        logic signed [DW-1:0] dir_re;
        logic signed [DW-1:0] dir_im;
        logic                 dz;
        logic                 sat;
        logic                 neg_re;
        logic                 neg_im;
        logic [PW-1:0]        mag_re;
        logic [PW-1:0]        mag_im;
        logic [PW-1:0]        den;
        logic [PW-1:0]        sq_x;
    } cau_q_t;

endpackage

`default_nettype wire

### rtl/core/cau_front.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit front end
// Accepts requests, forms all products in one registered stage, then
// finishes add, subtract, multiply and the supremum norm and prepares the
// divide and magnitude work for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [2:0]                    op,
    input  wire logic signed [cau_pkg::DW-1:0] a_re,
    input  wire logic signed [cau_pkg::DW-1:0] a_im,
    input  wire logic signed [cau_pkg::DW-1:0] b_re,
    input  wire logic signed [cau_pkg::DW-1:0] b_im,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output cau_pkg::cau_q_t                    out_data
);

    localparam int DW = cau_pkg::DW;
    localparam int PW = cau_pkg::PW;
    localparam int FW = cau_pkg::FW;

    localparam logic signed [PW:0] LIM_HI = {{(PW+1-DW){1'b0}}, cau_pkg::SMAX};
    localparam logic signed [PW:0] LIM_LO = {{(PW+1-DW){1'b1}}, cau_pkg::SMIN};

    logic                 vld_reg;
    logic [2:0]           op_reg;
    logic signed [DW-1:0] ar_reg, ai_reg, br_reg, bi_reg;
    logic signed [PW-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic                 take;

    logic signed [DW:0]   add_re, add_im, sub_re, sub_im;
    logic signed [PW:0]   mul_re, mul_im, num_re, num_im, den_w, sq_w;
    logic signed [PW:0]   neg_num_re, neg_num_im;
    logic [DW:0]          abs_re, abs_im, sup_w;
    logic                 is_mag;

    // Clip a wide signed value to the data range.
    function automatic logic signed [DW-1:0] clip_val(input logic signed [PW:0] v);
        logic signed [DW-1:0] r;
        if (v > LIM_HI)
            r = cau_pkg::SMAX;
        else if (v < LIM_LO)
            r = cau_pkg::SMIN;
        else
            r = v[DW-1:0];
        return r;
    endfunction

    function automatic logic clip_hit(input logic signed [PW:0] v);
        return (v > LIM_HI) || (v < LIM_LO);
    endfunction

    function automatic logic signed [PW:0] ext_short(input logic signed [DW:0] v);
        return {{(PW-DW){v[DW]}}, v};
    endfunction

    // The stage empties when its content moves on into the queue.
    assign take      = in_valid && in_ready;
    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign is_mag    = (op == cau_pkg::OP_MAG);

    // Valid flag of the product stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (take)
            vld_reg <= 1'b1;
        else if (out_ready)
            vld_reg <= 1'b0;
    end

    // Operands and products; the first two products become squares for magnitude.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg <= op;
            ar_reg <= a_re;
            ai_reg <= a_im;
            br_reg <= b_re;
            bi_reg <= b_im;
            p0_reg <= a_re * (is_mag ? a_re : b_re);
            p1_reg <= a_im * (is_mag ? a_im : b_im);
            p2_reg <= a_re * b_im;
            p3_reg <= a_im * b_re;
            p4_reg <= b_re * b_re;
            p5_reg <= b_im * b_im;
        end
    end

    // Sums and differences of the operands and of the products, and the absolute values for the supremum norm.
    always_comb
    begin
        add_re = {ar_reg[DW-1], ar_reg} + {br_reg[DW-1], br_reg};
        add_im = {ai_reg[DW-1], ai_reg} + {bi_reg[DW-1], bi_reg};
        sub_re = {ar_reg[DW-1], ar_reg} - {br_reg[DW-1], br_reg};
        sub_im = {ai_reg[DW-1], ai_reg} - {bi_reg[DW-1], bi_reg};
        mul_re = $signed({p0_reg[PW-1], p0_reg} - {p1_reg[PW-1], p1_reg}) >>> FW;
        mul_im = $signed({p2_reg[PW-1], p2_reg} + {p3_reg[PW-1], p3_reg}) >>> FW;
        num_re = {p0_reg[PW-1], p0_reg} + {p1_reg[PW-1], p1_reg};
        num_im = {p3_reg[PW-1], p3_reg} - {p2_reg[PW-1], p2_reg};
        neg_num_re = -num_re;
        neg_num_im = -num_im;
        den_w  = {p4_reg[PW-1], p4_reg} + {p5_reg[PW-1], p5_reg};
        sq_w   = {p0_reg[PW-1], p0_reg} + {p1_reg[PW-1], p1_reg};
        abs_re = ar_reg[DW-1] ? -{ar_reg[DW-1], ar_reg} : {ar_reg[DW-1], ar_reg};
        abs_im = ai_reg[DW-1] ? -{ai_reg[DW-1], ai_reg} : {ai_reg[DW-1], ai_reg};
        sup_w  = (abs_re > abs_im) ? abs_re : abs_im;
    end

    // Classify the request and finish the short operations.
    always_comb
    begin
        out_data        = '0;
        out_data.kind   = cau_pkg::K_DIRECT;
        out_data.neg_re = num_re[PW];
        out_data.neg_im = num_im[PW];
        out_data.mag_re = num_re[PW] ? neg_num_re[PW-1:0] : num_re[PW-1:0];
        out_data.mag_im = num_im[PW] ? neg_num_im[PW-1:0] : num_im[PW-1:0];
        out_data.den    = den_w[PW-1:0];
        out_data.sq_x   = sq_w[PW-1:0];
        case (op_reg)
            cau_pkg::OP_ADD:
            begin
                out_data.dir_re = clip_val(ext_short(add_re));
                out_data.dir_im = clip_val(ext_short(add_im));
                out_data.sat    = clip_hit(ext_short(add_re)) || clip_hit(ext_short(add_im));
            end
            cau_pkg::OP_SUB:
            begin
                out_data.dir_re = clip_val(ext_short(sub_re));
                out_data.dir_im = clip_val(ext_short(sub_im));
                out_data.sat    = clip_hit(ext_short(sub_re)) || clip_hit(ext_short(sub_im));
            end
            cau_pkg::OP_MUL:
            begin
                out_data.dir_re = clip_val(mul_re);
                out_data.dir_im = clip_val(mul_im);
                out_data.sat    = clip_hit(mul_re) || clip_hit(mul_im);
            end
            cau_pkg::OP_DIV:
            begin
                // A zero divisor gives a zero result and the error flag.
                if (den_w == '0)
                    out_data.dz = 1'b1;
                else
                    out_data.kind = cau_pkg::K_DIV;
            end
            cau_pkg::OP_MAG:
            begin
                out_data.kind = cau_pkg::K_MAG;
            end
            cau_pkg::OP_SUP:
            begin
                out_data.dir_re = clip_val({{(PW-DW){1'b0}}, sup_w});
                out_data.sat    = clip_hit({{(PW-DW){1'b0}}, sup_w});
            end
            default:
            begin
                out_data.kind = cau_pkg::K_DIRECT;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/cau_queue.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit queue
// Small first-in first-out buffer that decouples the front end from the
// back end so that each side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire cau_pkg::cau_q_t in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output cau_pkg::cau_q_t      out_data
);

    localparam int QAW = cau_pkg::QAW;

    cau_pkg::cau_q_t mem_reg [cau_pkg::QDEPTH];
    logic [QAW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]    count_reg, count_next;
    logic            push, pop;

    assign in_ready  = (count_reg != QAW'(0) + (QAW+1)'(cau_pkg::QDEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_data;
    end

endmodule

`default_nettype wire

### rtl/core/cau_back.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit back end
// Pipelined restoring divider (two lanes) and integer square root, one
// result bit per stage, followed by sign, clipping and an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire cau_pkg::cau_q_t       in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [cau_pkg::DW-1:0]     res_re,
    output logic [cau_pkg::DW-1:0]     res_im,
    output logic                       div_zero,
    output logic                       saturated
);

    localparam int DW  = cau_pkg::DW;
    localparam int PW  = cau_pkg::PW;
    localparam int RW  = cau_pkg::RW;
    localparam int CW  = cau_pkg::CW;
    localparam int FW  = cau_pkg::FW;
    localparam int NST = cau_pkg::NST;

    typedef struct packed {
        logic [1:0]           kind;
        logic signed [DW-1:0] dir_re;
        logic signed [DW-1:0] dir_im;
        logic                 dz;
        logic                 sat;
        logic                 neg_re;
        logic                 neg_im;
        logic                 ovf_re;
        logic                 ovf_im;
        logic [RW-1:0]        rem_re;
        logic [RW-1:0]        rem_im;
        logic [DW-1:0]        q_re;
        logic [DW-1:0]        q_im;
        logic [PW-1:0]        den;
        logic [PW-1:0]        sq_x;
        logic [PW-1:0]        sq_r;
    } bk_t;

    logic                 vld_reg [NST];
    bk_t                  st_reg  [NST];
    bk_t                  st_next [NST];
    logic                 en;
    logic                 ovld_reg;
    logic signed [DW-1:0] ore_reg, oim_reg, ore_next, oim_next;
    logic                 odz_reg, osat_reg, odz_next, osat_next;
    logic [CW-1:0]        dd_re, dd_im, dlim;

    // Sign and clip a quotient.
    function automatic logic signed [DW-1:0] div_val(input logic ovf, input logic neg,
                                                     input logic [DW-1:0] q);
        logic signed [DW-1:0] r;
        if (neg)
        begin
            if (ovf || (q > {1'b1, {(DW-1){1'b0}}}))
                r = cau_pkg::SMIN;
            else
                r = -q;
        end
        else
        begin
            if (ovf || (q > cau_pkg::SMAX))
                r = cau_pkg::SMAX;
            else
                r = q;
        end
        return r;
    endfunction

    function automatic logic div_hit(input logic ovf, input logic neg, input logic [DW-1:0] q);
        logic h;
        if (neg)
            h = ovf || (q > {1'b1, {(DW-1){1'b0}}});
        else
            h = ovf || (q > cau_pkg::SMAX);
        return h;
    endfunction

    // The whole pipeline moves when the output register is free or taken.
    assign en       = !ovld_reg || out_ready;
    assign in_ready = en;

    // Setup stage with the scaled dividends and the quotient overflow check,
    // then one quotient bit and one root bit per stage.
    always_comb
    begin
        dd_re = CW'(in_data.mag_re) << FW;
        dd_im = CW'(in_data.mag_im) << FW;
        dlim  = CW'(in_data.den) << DW;
        st_next[0]        = '0;
        st_next[0].kind   = in_data.kind;
        st_next[0].dir_re = in_data.dir_re;
        st_next[0].dir_im = in_data.dir_im;
        st_next[0].dz     = in_data.dz;
        st_next[0].sat    = in_data.sat;
        st_next[0].neg_re = in_data.neg_re;
        st_next[0].neg_im = in_data.neg_im;
        st_next[0].ovf_re = (dd_re >= dlim);
        st_next[0].ovf_im = (dd_im >= dlim);
        st_next[0].rem_re = dd_re[RW-1:0];
        st_next[0].rem_im = dd_im[RW-1:0];
        st_next[0].den    = in_data.den;
        st_next[0].sq_x   = in_data.sq_x;
        for (int k = 0; k < NST - 1; k++)
        begin
            logic [RW-1:0] dsh;
            logic [RW:0]   tr_re, tr_im;
            logic [PW-1:0] rbit;
            logic [PW:0]   trial;
            st_next[k+1] = st_reg[k];
            dsh   = RW'(st_reg[k].den) << (DW - 1 - k);
            tr_re = {1'b0, st_reg[k].rem_re} - {1'b0, dsh};
            tr_im = {1'b0, st_reg[k].rem_im} - {1'b0, dsh};
            if (!tr_re[RW])
                st_next[k+1].rem_re = tr_re[RW-1:0];
            if (!tr_im[RW])
                st_next[k+1].rem_im = tr_im[RW-1:0];
            st_next[k+1].q_re = {st_reg[k].q_re[DW-2:0], !tr_re[RW]};
            st_next[k+1].q_im = {st_reg[k].q_im[DW-2:0], !tr_im[RW]};
            // Digit-by-digit square root.
            rbit  = PW'(1) << (2 * (DW - 1 - k));
            trial = {1'b0, st_reg[k].sq_r} + {1'b0, rbit};
            if ({1'b0, st_reg[k].sq_x} >= trial)
            begin
                st_next[k+1].sq_x = st_reg[k].sq_x - trial[PW-1:0];
                st_next[k+1].sq_r = (st_reg[k].sq_r >> 1) + rbit;
            end
            else
            begin
                st_next[k+1].sq_r = st_reg[k].sq_r >> 1;
            end
        end
    end

    // Stage registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NST; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < NST; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NST; k++)
                st_reg[k] <= st_next[k];
        end
    end

    // Final sign, clipping and flags.
    always_comb
    begin
        ore_next  = st_reg[NST-1].dir_re;
        oim_next  = st_reg[NST-1].dir_im;
        odz_next  = st_reg[NST-1].dz;
        osat_next = st_reg[NST-1].sat;
        case (st_reg[NST-1].kind)
            cau_pkg::K_DIV:
            begin
                ore_next  = div_val(st_reg[NST-1].ovf_re, st_reg[NST-1].neg_re,
                                    st_reg[NST-1].q_re);
                oim_next  = div_val(st_reg[NST-1].ovf_im, st_reg[NST-1].neg_im,
                                    st_reg[NST-1].q_im);
                odz_next  = 1'b0;
                osat_next = div_hit(st_reg[NST-1].ovf_re, st_reg[NST-1].neg_re,
                                    st_reg[NST-1].q_re)
                         || div_hit(st_reg[NST-1].ovf_im, st_reg[NST-1].neg_im,
                                    st_reg[NST-1].q_im);
            end
            cau_pkg::K_MAG:
            begin
                oim_next  = '0;
                odz_next  = 1'b0;
                osat_next = (st_reg[NST-1].sq_r > PW'(cau_pkg::SMAX));
                ore_next  = osat_next ? cau_pkg::SMAX : st_reg[NST-1].sq_r[DW-1:0];
            end
            default:
            begin
                ore_next = st_reg[NST-1].dir_re;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovld_reg <= 1'b0;
        else if (en)
            ovld_reg <= vld_reg[NST-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ore_reg  <= ore_next;
            oim_reg  <= oim_next;
            odz_reg  <= odz_next;
            osat_reg <= osat_next;
        end
    end

    assign out_valid = ovld_reg;
    assign res_re    = ore_reg;
    assign res_im    = oim_reg;
    assign div_zero  = odz_reg;
    assign saturated = osat_reg;

endmodule

`default_nettype wire

### rtl/core/complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Signed Q8.8 complex add, subtract, multiply, divide, magnitude and
// supremum norm on a stream, one request per clock while m_tready is high.
//
// Usage:
//   The s_ channel takes one request per handshake: op in s_tuser, the
//   operands a_re, a_im, b_re, b_im in s_tdata. The m_ channel returns one
//   result per request, in order: res_re, res_im in m_tdata, div_zero and
//   saturated in m_tuser.
//   Throughput is one request per cycle while m_tready is high. A request
//   of Q8.8 operands passes through one product stage, the queue storage,
//   a setup stage, DW divider/square root stages (one quotient and root
//   bit each) and the output register. The divider pipeline sets the latency.
//   When m_tready is low and a result is waiting, the back end holds; the
//   four-entry queue and the product stage keep taking requests until
//   they fill, then s_tready drops. Reset empties the queue and
//   pipelines; no result is pending after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_arithmetic_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [cau_pkg::IN_TW-1:0]     s_tdata,   // a_re, a_im, b_re, b_im
    input  wire logic [cau_pkg::IN_UW-1:0]     s_tuser,   // op
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [cau_pkg::OUT_TW-1:0]         m_tdata,   // res_re, res_im
    output logic [cau_pkg::OUT_UW-1:0]         m_tuser    // div_zero, saturated
);

    localparam int DW = cau_pkg::DW;

    logic            fq_valid, fq_ready, qb_valid, qb_ready;
    cau_pkg::cau_q_t fq_data, qb_data;
    logic [DW-1:0]   res_re, res_im;
    logic            div_zero, saturated;

    // Front end: products and short operations.
    cau_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .op        (s_tuser[2:0]),
        .a_re      (s_tdata[DW-1:0]),
        .a_im      (s_tdata[2*DW-1:DW]),
        .b_re      (s_tdata[3*DW-1:2*DW]),
        .b_im      (s_tdata[4*DW-1:3*DW]),
        .out_valid (fq_valid),
        .out_ready (fq_ready),
        .out_data  (fq_data)
    );

    // Queue between the two ends.
    cau_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    // Back end: divider, square root and output register.
    cau_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (qb_valid),
        .in_ready  (qb_ready),
        .in_data   (qb_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .res_re    (res_re),
        .res_im    (res_im),
        .div_zero  (div_zero),
        .saturated (saturated)
    );

    // Output packing, padded with zeros to whole bytes.
    assign m_tdata = cau_pkg::OUT_TW'({res_im, res_re});
    assign m_tuser = {saturated, div_zero};

endmodule

`default_nettype wire
